@@ rtl/core/bgp_path_attribute_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the path attribute parser RTL.
// Each macro checks a property on the rising clock edge and is disabled while
// the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BGP_PATH_ATTRIBUTE_PARSER_ASSERT_SVH
`define BGP_PATH_ATTRIBUTE_PARSER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define BGPA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define BGPA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bgpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bgpa_pkg
// Types and constants for the path attribute parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bgpa_pkg;

    // Width of the section byte counter; section lengths are masked to it.
    localparam int SECTION_LEN_BITS = 12;
    localparam int ATTR_LEN_BITS    = 16;

    // Header sizes and the extended length flag bit.
    localparam int MIN_HEADER_BYTES = 3;
    localparam int EXT_LEN_BYTES    = 2;
    localparam int FLAG_EXT_BIT     = 4;

    typedef logic [SECTION_LEN_BITS-1:0] rem_t;
    typedef logic [ATTR_LEN_BITS-1:0]    attr_len_t;

    // Parser phase within one attribute.
    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_VALUE  = 3'd4
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TRUNC   = 2'd2,
        KIND_OVERRUN = 2'd3
    } kind_t;

endpackage

`default_nettype wire

@@ rtl/core/bgpa_if.sv @@
// ----------------------------------------------------------------------------
// bgpa_byte_if / bgpa_result_if
// Valid/ready channels for section bytes and for parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpa_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        section_start;
    logic [11:0] section_length;

    modport source (output valid, output data_byte, output section_start,
                    output section_length, input ready);
    modport sink   (input valid, input data_byte, input section_start,
                    input section_length, output ready);
endinterface

interface bgpa_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  attr_type;
    logic [15:0] attr_length;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        value_last;
    logic        section_done;

    modport source (output valid, output kind, output attr_type, output attr_length,
                    output value_byte, output value_index, output value_last,
                    output section_done, input ready);
    modport sink   (input valid, input kind, input attr_type, input attr_length,
                    input value_byte, input value_index, input value_last,
                    input section_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bgpa_in_reg.sv @@
// ----------------------------------------------------------------------------
// bgpa_in_reg
// Input register stage: holds one section byte request for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpa_in_reg (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bgpa_byte_if.sink   up,
    bgpa_byte_if.source dn
);

    logic        valid_reg;
    logic [7:0]  data_byte_reg;
    logic        section_start_reg;
    logic [11:0] section_length_reg;

    // The stage takes a new request when empty or when its content moves on.
    assign up.ready = !valid_reg || dn.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            data_byte_reg      <= up.data_byte;
            section_start_reg  <= up.section_start;
            section_length_reg <= up.section_length;
        end
    end

    assign dn.valid          = valid_reg;
    assign dn.data_byte      = data_byte_reg;
    assign dn.section_start  = section_start_reg;
    assign dn.section_length = section_length_reg;

endmodule

`default_nettype wire

@@ rtl/core/bgpa_core.sv @@
// ----------------------------------------------------------------------------
// bgpa_core
// Attribute parsing state machine: one section byte per cycle in unless the
// result side stalls, at most one result out, with header checks and error dropping.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpa_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bgpa_byte_if.sink     up,
    bgpa_result_if.source dn
);

    localparam int LEN_W = bgpa_pkg::ATTR_LEN_BITS;

    // Parser state.
    bgpa_pkg::phase_t    phase_reg, phase_next;
    bgpa_pkg::rem_t      remaining_reg, remaining_next;
    logic                ext_reg, ext_next;
    logic [7:0]          type_reg, type_next;
    bgpa_pkg::attr_len_t len_reg, len_next;
    bgpa_pkg::attr_len_t cnt_reg, cnt_next;
    logic                drop_reg, drop_next;

    // State as seen by this byte once a section start has been applied.
    bgpa_pkg::phase_t    phase_cur;
    bgpa_pkg::rem_t      rem_cur;
    logic                ext_cur;
    logic [7:0]          type_cur;
    bgpa_pkg::attr_len_t len_cur;
    bgpa_pkg::attr_len_t cnt_cur;
    logic                drop_cur;

    logic                st;
    logic [7:0]          d;
    logic                fire;
    logic                active;
    bgpa_pkg::rem_t      after;
    logic                after_zero;
    bgpa_pkg::attr_len_t len_lo_val;
    logic                short_hdr;
    logic                cut_ext;
    logic                overrun;
    logic                val_last;
    logic                emit;

    assign st   = up.section_start;
    assign d    = up.data_byte;
    assign fire = up.valid && up.ready;

    // The parser advances only when the result register can take a result.
    assign up.ready = dn.ready;

    // A section start reloads the byte count and clears the attribute state.
    assign phase_cur = st ? bgpa_pkg::PH_FLAGS : phase_reg;
    assign rem_cur   = st ? bgpa_pkg::rem_t'(up.section_length) : remaining_reg;
    assign ext_cur   = st ? 1'b0 : ext_reg;
    assign type_cur  = st ? 8'h00 : type_reg;
    assign len_cur   = st ? '0 : len_reg;
    assign cnt_cur   = st ? '0 : cnt_reg;
    assign drop_cur  = st ? 1'b0 : drop_reg;

    // Shared checks for the current byte.
    assign active     = (rem_cur != '0);
    assign after      = rem_cur - bgpa_pkg::rem_t'(1);
    assign after_zero = (after == '0);
    assign len_lo_val = ext_cur ? {len_cur[LEN_W-1:8], d} : {{(LEN_W-8){1'b0}}, d};
    assign short_hdr  = (rem_cur < bgpa_pkg::rem_t'(bgpa_pkg::MIN_HEADER_BYTES));
    assign cut_ext    = ext_cur && (after < bgpa_pkg::rem_t'(bgpa_pkg::EXT_LEN_BYTES));
    assign overrun    = (len_lo_val > LEN_W'(after));
    assign val_last   = ({1'b0, cnt_cur} + (LEN_W+1)'(1)) >= {1'b0, len_cur};

    // Next state.
    always_comb
    begin
        phase_next     = phase_cur;
        remaining_next = active ? after : rem_cur;
        ext_next       = ext_cur;
        type_next      = type_cur;
        len_next       = len_cur;
        cnt_next       = cnt_cur;
        drop_next      = drop_cur;
        if (active)
        begin
            if (drop_cur)
            begin
                if (after_zero)
                begin
                    drop_next = 1'b0;
                end
                phase_next = bgpa_pkg::PH_FLAGS;
            end
            else
            begin
                case (phase_cur)
                    bgpa_pkg::PH_FLAGS:
                    begin
                        type_next = 8'h00;
                        len_next  = '0;
                        cnt_next  = '0;
                        if (short_hdr)
                        begin
                            drop_next  = !after_zero;
                            phase_next = bgpa_pkg::PH_FLAGS;
                        end
                        else
                        begin
                            ext_next   = d[bgpa_pkg::FLAG_EXT_BIT];
                            phase_next = bgpa_pkg::PH_TYPE;
                        end
                    end
                    bgpa_pkg::PH_TYPE:
                    begin
                        type_next = d;
                        if (cut_ext)
                        begin
                            drop_next  = !after_zero;
                            phase_next = bgpa_pkg::PH_FLAGS;
                        end
                        else if (ext_cur)
                        begin
                            phase_next = bgpa_pkg::PH_LEN_HI;
                        end
                        else
                        begin
                            phase_next = bgpa_pkg::PH_LEN_LO;
                        end
                    end
                    bgpa_pkg::PH_LEN_HI:
                    begin
                        len_next   = {d, 8'h00};
                        phase_next = bgpa_pkg::PH_LEN_LO;
                    end
                    bgpa_pkg::PH_LEN_LO:
                    begin
                        len_next = len_lo_val;
                        if (overrun)
                        begin
                            drop_next  = !after_zero;
                            phase_next = bgpa_pkg::PH_FLAGS;
                        end
                        else if (len_lo_val == '0)
                        begin
                            phase_next = bgpa_pkg::PH_FLAGS;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            phase_next = bgpa_pkg::PH_VALUE;
                        end
                    end
                    bgpa_pkg::PH_VALUE:
                    begin
                        cnt_next = cnt_cur + LEN_W'(1);
                        if (val_last)
                        begin
                            phase_next = bgpa_pkg::PH_FLAGS;
                        end
                    end
                    default:
                    begin
                        phase_next = bgpa_pkg::PH_FLAGS;
                    end
                endcase
            end
        end
    end

    // Result generation.
    always_comb
    begin
        emit            = 1'b0;
        dn.kind         = bgpa_pkg::KIND_VALUE;
        dn.attr_type    = type_cur;
        dn.attr_length  = len_cur;
        dn.value_byte   = 8'h00;
        dn.value_index  = '0;
        dn.value_last   = 1'b0;
        dn.section_done = 1'b0;
        if (active && !drop_cur)
        begin
            case (phase_cur)
                bgpa_pkg::PH_FLAGS:
                begin
                    if (short_hdr)
                    begin
                        emit           = 1'b1;
                        dn.kind        = bgpa_pkg::KIND_TRUNC;
                        dn.attr_type   = 8'h00;
                        dn.attr_length = '0;
                    end
                end
                bgpa_pkg::PH_TYPE:
                begin
                    if (cut_ext)
                    begin
                        emit         = 1'b1;
                        dn.kind      = bgpa_pkg::KIND_TRUNC;
                        dn.attr_type = d;
                    end
                end
                bgpa_pkg::PH_LEN_LO:
                begin
                    dn.attr_length = len_lo_val;
                    if (overrun)
                    begin
                        emit    = 1'b1;
                        dn.kind = bgpa_pkg::KIND_OVERRUN;
                    end
                    else if (len_lo_val == '0)
                    begin
                        emit            = 1'b1;
                        dn.kind         = bgpa_pkg::KIND_EMPTY;
                        dn.section_done = after_zero;
                    end
                end
                bgpa_pkg::PH_VALUE:
                begin
                    emit            = 1'b1;
                    dn.kind         = bgpa_pkg::KIND_VALUE;
                    dn.value_byte   = d;
                    dn.value_index  = cnt_cur;
                    dn.value_last   = val_last;
                    dn.section_done = val_last && after_zero;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign dn.valid = up.valid && emit;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bgpa_pkg::PH_FLAGS;
            remaining_reg <= '0;
            ext_reg       <= 1'b0;
            type_reg      <= 8'h00;
            len_reg       <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            ext_reg       <= ext_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
        end
    end

`include "bgp_path_attribute_parser_assert.svh"

    // While dropping, the parser always waits at the flags phase.
    `BGPA_ASSERT_IMPLY(a_drop_phase, drop_reg, phase_reg == bgpa_pkg::PH_FLAGS,
        "drop outside flags phase")
    // Error results never end a section successfully.
    `BGPA_ASSERT_IMPLY(a_err_not_done,
        dn.valid && (dn.kind == bgpa_pkg::KIND_TRUNC || dn.kind == bgpa_pkg::KIND_OVERRUN),
        !dn.section_done, "error result marked done")
    // A value byte index stays inside the attribute value.
    `BGPA_ASSERT_IMPLY(a_idx_range, dn.valid && dn.kind == bgpa_pkg::KIND_VALUE,
        dn.value_index < dn.attr_length, "value index past length")
    // A section ends only on an empty attribute or on a final value byte.
    `BGPA_ASSERT_IMPLY(a_done_kind, dn.valid && dn.section_done,
        dn.kind == bgpa_pkg::KIND_EMPTY || dn.value_last, "section done on wrong result")

endmodule

`default_nettype wire

@@ rtl/core/bgpa_out_reg.sv @@
// ----------------------------------------------------------------------------
// bgpa_out_reg
// Result register stage: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpa_out_reg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bgpa_result_if.sink   up,
    bgpa_result_if.source dn
);

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  attr_type_reg;
    logic [15:0] attr_length_reg;
    logic [7:0]  value_byte_reg;
    logic [15:0] value_index_reg;
    logic        value_last_reg;
    logic        section_done_reg;

    // Free when empty or when the held result is being taken.
    assign up.ready = !valid_reg || dn.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            kind_reg         <= up.kind;
            attr_type_reg    <= up.attr_type;
            attr_length_reg  <= up.attr_length;
            value_byte_reg   <= up.value_byte;
            value_index_reg  <= up.value_index;
            value_last_reg   <= up.value_last;
            section_done_reg <= up.section_done;
        end
    end

    assign dn.valid        = valid_reg;
    assign dn.kind         = kind_reg;
    assign dn.attr_type    = attr_type_reg;
    assign dn.attr_length  = attr_length_reg;
    assign dn.value_byte   = value_byte_reg;
    assign dn.value_index  = value_index_reg;
    assign dn.value_last   = value_last_reg;
    assign dn.section_done = section_done_reg;

endmodule

`default_nettype wire

@@ rtl/core/bgp_path_attribute_parser.sv @@
// A byte is held in the input register, parsed combinationally, and its result is
// loaded into the result register, from which the sink takes it.
// Throughput: one section byte per cycle; a result held in the result register stalls
// the parser, and byte requests stop once the input register is full as well.
// Reset (rst_n low, asynchronous) empties both register stages and returns the
// parser to the flags phase with no section open.
// ----------------------------------------------------------------------------
// bgp_path_attribute_parser
// Top level: input register, attribute parser and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgp_path_attribute_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bgpa_byte_if.sink     byte_stream,
    bgpa_result_if.source result_stream
);

    bgpa_byte_if   held_bytes ();
    bgpa_result_if parsed ();

    // Input register stage.
    bgpa_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (byte_stream),
        .dn    (held_bytes)
    );

    // Parser.
    bgpa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (held_bytes),
        .dn    (parsed)
    );

    // Result register stage.
    bgpa_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (parsed),
        .dn    (result_stream)
    );

endmodule

`default_nettype wire

@@ tb/tb_bgp_path_attribute_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bgp_path_attribute_parser
// Self-checking bench for the path attribute parser. Section bytes are sent
// as directed sections and then as random attribute lists, some well formed
// and some cut short, padded, abandoned or mixed with stray bytes. A tracker
// object mirrors the parser state, queues the expected results and checks
// each result request field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_bgp_path_attribute_parser;

    import bgpa_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int TARGET_BYTES = 1300;
    localparam int LONG_HOLD    = 300;

    // One parser result, as seen on the result channel.
    typedef struct {
        kind_t       kind;
        logic [7:0]  attr_type;
        attr_len_t   attr_length;
        logic [7:0]  value_byte;
        attr_len_t   value_index;
        logic        value_last;
        logic        section_done;
    } attr_result_t;

    // Mirrors the attribute walk and holds the results still owed by the block.
    class attr_result_tracker;
        phase_t       phase;
        rem_t         remaining;
        bit           ext_len;
        logic [7:0]   cur_type;
        attr_len_t    cur_len;
        attr_len_t    value_count;
        bit           dropping;
        attr_result_t expected_q[$];
        int           mismatches;
        int           results_checked;
        int           kind_seen[4];

        function new();
            phase       = PH_FLAGS;
            remaining   = '0;
            ext_len     = 1'b0;
            cur_type    = '0;
            cur_len     = '0;
            value_count = '0;
            dropping    = 1'b0;
            mismatches  = 0;
            results_checked = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(kind_t k, logic [7:0] vb, attr_len_t idx, bit last,
                                  bit done);
            attr_result_t r;
            r.kind         = k;
            r.attr_type    = cur_type;
            r.attr_length  = cur_len;
            r.value_byte   = vb;
            r.value_index  = idx;
            r.value_last   = last;
            r.section_done = done;
            expected_q.push_back(r);
        endfunction

        // A malformed attribute: one error result, then the section tail is dropped.
        function void flag_error(kind_t k, int after);
            push_result(k, 8'h00, '0, 1'b0, 1'b0);
            dropping = (after != 0);
            phase    = PH_FLAGS;
        endfunction

        // Advance the mirrored parser by one accepted byte request.
        function void note_byte(logic [7:0] d, logic st, logic [11:0] len);
            int after;
            bit last;
            if (st)
            begin
                remaining   = rem_t'(len);
                phase       = PH_FLAGS;
                dropping    = 1'b0;
                ext_len     = 1'b0;
                cur_type    = '0;
                cur_len     = '0;
                value_count = '0;
            end
            if (remaining == 0)
                return;
            after     = int'(remaining) - 1;
            remaining = rem_t'(after);

            if (dropping)
            begin
                if (after == 0)
                    dropping = 1'b0;
                phase = PH_FLAGS;
                return;
            end

            case (phase)
                PH_FLAGS:
                begin
                    cur_type    = '0;
                    cur_len     = '0;
                    value_count = '0;
                    if (after + 1 < MIN_HEADER_BYTES)
                        flag_error(KIND_TRUNC, after);
                    else
                    begin
                        ext_len = d[FLAG_EXT_BIT];
                        phase   = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    cur_type = d;
                    if (!ext_len)
                        phase = PH_LEN_LO;
                    else if (after < EXT_LEN_BYTES)
                        flag_error(KIND_TRUNC, after);
                    else
                        phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    cur_len = {d, 8'h00};
                    phase   = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    cur_len = ext_len ? {cur_len[15:8], d} : {8'h00, d};
                    if (int'(cur_len) > after)
                        flag_error(KIND_OVERRUN, after);
                    else if (cur_len == 0)
                    begin
                        push_result(KIND_EMPTY, 8'h00, '0, 1'b0, after == 0);
                        phase = PH_FLAGS;
                    end
                    else
                    begin
                        value_count = '0;
                        phase       = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    last = (int'(value_count) + 1 >= int'(cur_len));
                    push_result(KIND_VALUE, d, value_count, last, last && after == 0);
                    value_count = value_count + 1'b1;
                    if (last)
                        phase = PH_FLAGS;
                end
                default:
                    phase = PH_FLAGS;
            endcase
        endfunction

        // Printing stops after a while so a broken block cannot flood the log.
        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [15:0] got_v, logic [15:0] want_v);
            if (got_v !== want_v)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 results_checked, name, got_v, want_v));
        endtask

        // Compare one accepted result request with the oldest expectation.
        task check_result(attr_result_t got);
            attr_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result, kind %0d type %0h",
                                 got.kind, got.attr_type));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            kind_seen[int'(want.kind)]++;
            check_field("kind", 16'(got.kind), 16'(want.kind));
            check_field("attr_type", 16'(got.attr_type), 16'(want.attr_type));
            check_field("attr_length", got.attr_length, want.attr_length);
            check_field("value_byte", 16'(got.value_byte), 16'(want.value_byte));
            check_field("value_index", got.value_index, want.value_index);
            check_field("value_last", 16'(got.value_last), 16'(want.value_last));
            check_field("section_done", 16'(got.section_done), 16'(want.section_done));
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_q.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bgpa_byte_if   byte_ch ();
    bgpa_result_if res_ch ();

    bgp_path_attribute_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_ch),
        .result_stream (res_ch)
    );

    attr_result_tracker tracker = new();

    logic [7:0] sect_bytes[$];
    bit         tx_steady;
    int         rx_hold_request;
    int         section_items;
    int         sections_sent;
    int         idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one byte request and hold it until the parser takes it.
    task automatic send_byte(input logic [7:0] d, input logic st, input logic [11:0] len);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= d;
        byte_ch.section_start  <= st;
        byte_ch.section_length <= len;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Send the built section; the first byte opens it with the given length.
    task automatic send_section(input int sect_len);
        foreach (sect_bytes[i])
            send_byte(sect_bytes[i], i == 0, (i == 0) ? 12'(sect_len) : 12'($urandom));
        section_items += (sect_len < sect_bytes.size()) ? sect_len : sect_bytes.size();
        sections_sent++;
    endtask

    function automatic void append_attr(bit ext, int vlen);
        logic [7:0] flags;
        flags               = 8'($urandom);
        flags[FLAG_EXT_BIT] = ext;
        sect_bytes.push_back(flags);
        sect_bytes.push_back(8'($urandom));
        if (ext)
            sect_bytes.push_back(8'(vlen >> 8));
        sect_bytes.push_back(8'(vlen));
        repeat (vlen) sect_bytes.push_back(8'($urandom));
    endfunction

    // Stop offering bytes until every owed result has come back.
    task automatic wait_for_results();
        byte_ch.valid <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
    endtask

    // Result side: random stalls, calm stretches and the requested long hold-off.
    initial
    begin : result_acceptor
        int low_left;
        int calm_left;
        low_left     = 0;
        calm_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                low_left        = rx_hold_request;
                rx_hold_request = 0;
            end
            if (low_left > 0)
            begin
                res_ch.ready <= 1'b0;
                low_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 3)
                    calm_left = $urandom_range(40, 200);
                else if ($urandom_range(0, 99) < 35)
                    low_left = pick_gap();
            end
        end
    end

    // Sample both channels at the rising edge; also watch for a stalled run.
    always @(posedge clk)
    begin
        attr_result_t got;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (byte_ch.valid && byte_ch.ready)
            begin
                tracker.note_byte(byte_ch.data_byte, byte_ch.section_start,
                                  byte_ch.section_length);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind         = kind_t'(res_ch.kind);
                got.attr_type    = res_ch.attr_type;
                got.attr_length  = res_ch.attr_length;
                got.value_byte   = res_ch.value_byte;
                got.value_index  = res_ch.value_index;
                got.value_last   = res_ch.value_last;
                got.section_done = res_ch.section_done;
                tracker.check_result(got);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int n_attr;
        int vlen;
        int r;
        int keep;
        int sect_len;
        bit ext;

        byte_ch.valid          = 1'b0;
        byte_ch.data_byte      = '0;
        byte_ch.section_start  = 1'b0;
        byte_ch.section_length = '0;
        rst_n                  = 1'b0;
        tx_steady              = 1'b0;
        rx_hold_request        = 0;
        section_items          = 0;
        sections_sent          = 0;
        idle_cycles            = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Stray byte with no section open, then an empty section start.
        send_byte(8'hFF, 1'b0, 12'hFFF);
        send_byte(8'hAA, 1'b1, 12'h000);
        // Short header: a one-byte section.
        sect_bytes = '{8'h00};
        send_section(1);
        // Zero-length attribute closing the section.
        sect_bytes = '{8'hEF, 8'h00, 8'h00};
        send_section(3);
        // Extended length attribute with extreme value bytes.
        sect_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF};
        send_section(6);
        // Extended length cut off by the section end, tail dropped.
        sect_bytes = '{8'h10, 8'h02, 8'h33};
        send_section(3);
        // Value longer than the section, tail dropped.
        sect_bytes = '{8'h40, 8'h03, 8'h05, 8'h77};
        send_section(4);
        // Largest extended length overruns on the last section byte.
        sect_bytes = '{8'h50, 8'h09, 8'hFF, 8'hFF};
        send_section(4);
        // Largest section abandoned by a new start, which then completes.
        sect_bytes = '{8'h40, 8'h05};
        send_section(4095);
        sect_bytes = '{8'h00, 8'h07, 8'h01, 8'hEE};
        send_section(4);

        // Random attribute lists, mostly well formed.
        while (section_items < TARGET_BYTES)
        begin
            sect_bytes.delete();
            tx_steady = ($urandom_range(0, 99) < 20);

            // Long hold on the result side while bytes keep coming.
            if (sections_sent == 20 || sections_sent == 70)
            begin
                rx_hold_request = LONG_HOLD;
                tx_steady       = 1'b1;
                repeat (3) append_attr($urandom_range(0, 1), $urandom_range(40, 70));
                send_section(sect_bytes.size());
                continue;
            end

            n_attr = $urandom_range(1, 4);
            repeat (n_attr)
            begin
                ext  = ($urandom_range(0, 3) == 0);
                r    = $urandom_range(0, 99);
                vlen = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                append_attr(ext, vlen);
            end
            sect_len = sect_bytes.size();

            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // Well formed as built.
            end
            else if (r < 80)
            begin
                // Section length too short; the bytes past it arrive outside.
                sect_len -= $urandom_range(1, (sect_len > 5) ? 5 : sect_len - 1);
            end
            else if (r < 87)
            begin
                // Garbage after the attributes is parsed as further headers.
                repeat ($urandom_range(1, 6)) sect_bytes.push_back(8'($urandom));
                sect_len = sect_bytes.size();
            end
            else if (r < 94)
            begin
                // Section cut off by the next start, sometimes with a huge length.
                keep = $urandom_range(1, sect_bytes.size() - 1);
                while (sect_bytes.size() > keep)
                    void'(sect_bytes.pop_back());
                if ($urandom_range(0, 3) == 0)
                    sect_len = $urandom_range(2048, 4095);
            end
            else
            begin
                // Stray bytes and empty section starts ahead of the section.
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 12'($urandom));
                if ($urandom_range(0, 1) == 1)
                    send_byte(8'($urandom), 1'b1, 12'h000);
            end
            send_section(sect_len);

            if (sections_sent % 50 == 0 || $urandom_range(0, 99) < 3)
                wait_for_results();
        end

        wait_for_results();
        repeat (10) @(negedge clk);

        $display("Covered %0d sections, %0d section bytes, %0d results checked",
                 sections_sent, section_items, tracker.results_checked);
        $display("Results: %0d value, %0d empty, %0d short header, %0d overrun",
                 tracker.kind_seen[KIND_VALUE], tracker.kind_seen[KIND_EMPTY],
                 tracker.kind_seen[KIND_TRUNC], tracker.kind_seen[KIND_OVERRUN]);
        tracker.close_out();
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
